// File: rtl/ksc_pkg.sv
// ============================================================================
// ksc_pkg
// Shared types, constants, the key layout lookup and the angle clamp for the key
// strike classifier.
// ============================================================================
package ksc_pkg;

  // Keys and the strike window
  localparam int NUM_KEYS       = 17;
  localparam int WINDOW_SAMPLES = 10;
  localparam int KEY_IDX_W      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CNT_W          = $clog2(WINDOW_SAMPLES + 2);

  // Field widths
  localparam int KEY_W      = 5;
  localparam int PRESSURE_W = 12;
  localparam int ANGLE_W    = 13;
  localparam int TIME_W     = 48;
  localparam int THRESH_W   = 13;
  localparam int KIND_W     = 2;
  localparam int STRIKE_W   = 2;
  localparam int POS_W      = 3;
  localparam int CFG_IDX_W  = 1;

  // Stream word widths, padded to whole bytes
  localparam int IN_DATA_BITS  = KEY_W + PRESSURE_W + 2 * ANGLE_W + TIME_W;
  localparam int IN_DATA_W     = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = KEY_W + PRESSURE_W + 2 * ANGLE_W + STRIKE_W
                                 + 2 * POS_W + TIME_W;
  localparam int OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GATE_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HARD_THRESHOLD = 1'd1;

  localparam logic [THRESH_W-1:0] GATE_THRESHOLD_RST = 13'd100;
  localparam logic [THRESH_W-1:0] HARD_THRESHOLD_RST = 13'd800;

  // Saturation limits of roll and yaw
  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 13'sd2048;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -13'sd2048;

  typedef enum logic [KIND_W-1:0] {
    EV_START    = 2'd0,
    EV_CONTINUE = 2'd1,
    EV_END      = 2'd2
  } event_kind_t;

  typedef enum logic [STRIKE_W-1:0] {
    STRIKE_NONE  = 2'd0,
    STRIKE_LIGHT = 2'd1,
    STRIKE_HARD  = 2'd2,
    STRIKE_SOFT  = 2'd3
  } strike_t;

  // Key layout: columns holding 4,4,4,4,1 keys
  localparam int LAYOUT_COLS = 5;
  localparam int COL_LEN [LAYOUT_COLS] = '{4, 4, 4, 4, 1};

  typedef struct packed {
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
  } key_pos_t;

  // Column and row of a key, both zero past the end of the layout
  function automatic key_pos_t key_locate(input logic [KEY_W-1:0] key);
    key_pos_t pos;
    int       base;
    logic     found;
    pos   = '0;
    base  = 0;
    found = 1'b0;
    for (int c = 0; c < LAYOUT_COLS; c++) begin
      if (!found && (int'(key) < base + COL_LEN[c])) begin
        pos.column = POS_W'(c + 1);
        pos.row    = POS_W'(int'(key) - base + 1);
        found      = 1'b1;
      end
      base = base + COL_LEN[c];
    end
    return pos;
  endfunction

  // Clamp a raw angle to the range ANGLE_MIN to ANGLE_MAX
  function automatic logic signed [ANGLE_W-1:0] angle_sat(
    input logic signed [ANGLE_W-1:0] v
  );
    logic signed [ANGLE_W-1:0] r;
    r = v;
    if (v > ANGLE_MAX) begin
      r = ANGLE_MAX;
    end else if (v < ANGLE_MIN) begin
      r = ANGLE_MIN;
    end
    return r;
  endfunction

endpackage

// File: rtl/key_strike_classifier.sv
// ============================================================================
// key_strike_classifier
// Per-key note tracking and strike classification over a scanned key stream.
// ============================================================================
// An accepted word goes through the input and result registers to out_tvalid.
// One word per cycle when not stalled; per-key state is read and written back
//   in the same cycle, so samples of the same key may follow back to back.
// Words with a key number past the last key are dropped without a result.
// Reset (rst_n low, synchronous): both stages empty, all per-key state
//   cleared, thresholds back to 100 (gate) and 800 (hard).
module key_strike_classifier
  import ksc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  // Input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [4:0] key_number, [16:5] pressure, [29:17] roll, [42:30] yaw,
  // [90:43] sample_time, [95:91] zero
  input  logic [IN_DATA_W-1:0]   in_tdata,
  // [0] pressed
  input  logic                   in_tuser,

  // Result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [4:0] key_out, [16:5] pressure_out, [29:17] roll_out, [42:30] yaw_out,
  // [44:43] strike, [47:45] key_column, [50:48] key_row,
  // [98:51] event_time, [103:99] zero
  output logic [OUT_DATA_W-1:0]  out_tdata,
  // [1:0] event_kind
  output logic [KIND_W-1:0]      out_tuser,

  // Configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [THRESH_W-1:0]    cfg_wdata
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [THRESH_W-1:0] gate_thr_r;
  logic [THRESH_W-1:0] hard_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_thr_r <= GATE_THRESHOLD_RST;
      hard_thr_r <= HARD_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GATE_THRESHOLD: gate_thr_r <= cfg_wdata;
        REG_HARD_THRESHOLD: hard_thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic                         s1_valid_r;
  logic [KEY_W-1:0]             s1_key_r;
  logic                         s1_pressed_r;
  logic [PRESSURE_W-1:0]        s1_pressure_r;
  logic signed [ANGLE_W-1:0]    s1_roll_r;
  logic signed [ANGLE_W-1:0]    s1_yaw_r;
  logic [TIME_W-1:0]            s1_time_r;

  logic out_valid_r;
  logic s1_go;      // the word in the input register moves on this cycle
  logic in_fire;

  // The input register drains whenever the result register is free or being
  // taken; a dropped word drains the same way, it just leaves no result.
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // Payload: no reset, load on accept
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_key_r      <= in_tdata[4:0];
      s1_pressure_r <= in_tdata[16:5];
      s1_roll_r     <= in_tdata[29:17];
      s1_yaw_r      <= in_tdata[42:30];
      s1_time_r     <= in_tdata[90:43];
      s1_pressed_r  <= in_tuser;
    end
  end

  // --------------------------------------------------------------------------
  // Per-key state: one entry per key, read and written at the staged key
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]      cnt_r    [NUM_KEYS];
  logic [PRESSURE_W-1:0] peak_r   [NUM_KEYS];
  logic                  sent_r   [NUM_KEYS];

  logic                  key_ok;
  logic [KEY_IDX_W-1:0]  kidx;
  logic [CNT_W-1:0]      cnt_cur;
  logic [PRESSURE_W-1:0] peak_cur;
  logic                  sent_cur;

  assign key_ok   = (int'(s1_key_r) < NUM_KEYS);
  assign kidx     = s1_key_r[KEY_IDX_W-1:0];
  assign cnt_cur  = key_ok ? cnt_r[kidx]  : '0;
  assign peak_cur = key_ok ? peak_r[kidx] : '0;
  assign sent_cur = key_ok ? sent_r[kidx] : 1'b0;

  // --------------------------------------------------------------------------
  // Classification
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]      cnt_nxt;
  logic [PRESSURE_W-1:0] peak_nxt;
  logic                  sent_nxt;
  event_kind_t           kind_nxt;
  strike_t               strike_nxt;
  logic [PRESSURE_W-1:0] pres_nxt;
  logic signed [ANGLE_W-1:0] roll_nxt;
  logic signed [ANGLE_W-1:0] yaw_nxt;
  logic [TIME_W-1:0]     time_nxt;
  logic [PRESSURE_W-1:0] peak_upd;
  logic                  sent_mid;

  assign peak_upd = (s1_pressure_r > peak_cur) ? s1_pressure_r : peak_cur;

  always_comb begin
    cnt_nxt    = cnt_cur;
    peak_nxt   = peak_cur;
    sent_nxt   = sent_cur;
    sent_mid   = sent_cur;
    kind_nxt   = EV_CONTINUE;
    strike_nxt = STRIKE_NONE;
    pres_nxt   = '0;
    roll_nxt   = '0;
    yaw_nxt    = '0;
    time_nxt   = s1_time_r;

    if (!s1_pressed_r) begin
      // Release: close the note, end time marked one later
      cnt_nxt  = '0;
      kind_nxt = EV_END;
      time_nxt = s1_time_r + TIME_W'(1);
    end else if (cnt_cur == '0) begin
      // First down sample: open the note, its pressure stays out of the peak
      cnt_nxt    = CNT_W'(1);
      peak_nxt   = '0;
      sent_nxt   = 1'b0;
      kind_nxt   = EV_START;
      strike_nxt = STRIKE_LIGHT;
    end else begin
      peak_nxt = peak_upd;
      pres_nxt = s1_pressure_r;
      roll_nxt = angle_sat(s1_roll_r);
      yaw_nxt  = angle_sat(s1_yaw_r);
      if (cnt_cur < CNT_W'(WINDOW_SAMPLES)) begin
        cnt_nxt = cnt_cur + CNT_W'(1);
      end else begin
        // Window end: check for a hard strike once
        if (cnt_cur == CNT_W'(WINDOW_SAMPLES)) begin
          cnt_nxt = CNT_W'(WINDOW_SAMPLES + 1);
          if ({1'b0, peak_upd} > hard_thr_r) begin
            strike_nxt = STRIKE_HARD;
            sent_mid   = 1'b1;
          end
        end
        // From the window end on: a soft strike, once per note
        if (!sent_mid && ({1'b0, peak_upd} > gate_thr_r)) begin
          strike_nxt = STRIKE_SOFT;
          sent_mid   = 1'b1;
        end
        sent_nxt = sent_mid;
      end
    end
  end

  // Write back the state of the staged key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        cnt_r[k]  <= '0;
        peak_r[k] <= '0;
        sent_r[k] <= 1'b0;
      end
    end else if (s1_go && key_ok) begin
      cnt_r[kidx]  <= cnt_nxt;
      peak_r[kidx] <= peak_nxt;
      sent_r[kidx] <= sent_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  key_pos_t              pos;
  logic [OUT_DATA_W-1:0] out_data_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [KIND_W-1:0]     out_kind_r;

  assign pos = key_locate(s1_key_r);

  assign out_data_nxt = {
    (OUT_DATA_W - OUT_DATA_BITS)'(0),
    time_nxt,
    pos.row,
    pos.column,
    strike_nxt,
    yaw_nxt,
    roll_nxt,
    pres_nxt,
    s1_key_r
  };

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= key_ok;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the word while stalled, load on advance
  always_ff @(posedge clk) begin
    if (s1_go && key_ok) begin
      out_data_r <= out_data_nxt;
      out_kind_r <= kind_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

endmodule

// File: rtl/ksc_checker.sv
// ============================================================================
// ksc_checker
// Port-level checks on the key strike classifier result stream.
// ============================================================================
module ksc_checker
  import ksc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [KIND_W-1:0]     out_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [THRESH_W-1:0]   cfg_wdata
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // Reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // End words carry no pressure and no strike
  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == EV_END) |->
      (out_tdata[16:5] == '0) && (out_tdata[44:43] == STRIKE_NONE))
    else $error("end word with pressure or strike");

  // Start words always report a light strike
  a_start_light: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == EV_START) |-> (out_tdata[44:43] == STRIKE_LIGHT))
    else $error("start word without light strike");

  // Only keys in range produce results
  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (int'(out_tdata[4:0]) < NUM_KEYS))
    else $error("result for a key out of range");

endmodule

bind key_strike_classifier ksc_checker u_ksc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_we     (cfg_we),
  .cfg_index  (cfg_index),
  .cfg_wdata  (cfg_wdata)
);
